FILE: sv/ple_pkg.sv
// Shared types, codes and sizes for the positional list engine.
package ple_pkg;

   localparam int CAPACITY  = 64;
   localparam int DATA_BITS = 32;

   // Count holds 0..CAPACITY; the index of a slot fits in the same width.
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int POS_BITS  = 8;
   localparam int CMP_BITS  = ((CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS) + 1;

   localparam int ACTION_BITS  = 3;
   localparam int STATUS_BITS  = 2;
   localparam int VALUE_BITS   = 32;
   localparam int COUNT_BITS   = 7;

   localparam logic [ACTION_BITS-1:0] ACT_ADD_FRONT = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_ADD_REAR  = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_DEL_FRONT = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_DEL_REAR  = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_INSERT_AT = 3'd4;
   localparam logic [ACTION_BITS-1:0] ACT_DELETE_AT = 3'd5;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RANGE     = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } op_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      op_type                 op;
      logic [CNT_BITS-1:0]    idx;
      logic [DATA_BITS-1:0]   data;
   } cmd_type;

endpackage

FILE: sv/ple_cell.sv
// One slot of the list: keeps its element, shifts with its neighbors.
module ple_cell (
   input  logic                            clock,
   input  ple_pkg::cmd_type                cmd,
   input  logic [ple_pkg::CNT_BITS-1:0]    cell_index,
   input  logic [ple_pkg::DATA_BITS-1:0]   left_data,
   input  logic [ple_pkg::DATA_BITS-1:0]   right_data,
   output logic [ple_pkg::DATA_BITS-1:0]   data,
   output logic [ple_pkg::DATA_BITS-1:0]   hit_data
);

   logic [ple_pkg::DATA_BITS-1:0] data_ff;
   logic [ple_pkg::DATA_BITS-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         ple_pkg::OP_INSERT: begin
            if (cell_index == cmd.idx) begin
               data_in = cmd.data;
            end else if (cell_index > cmd.idx) begin
               data_in = left_data;
            end
         end
         ple_pkg::OP_REMOVE: begin
            if (cell_index >= cmd.idx) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign hit_data = (cell_index == cmd.idx) ? data_ff : '0;

endmodule

FILE: sv/ple_ctrl.sv
// Command decode, range checks and the element count register.
module ple_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [ple_pkg::ACTION_BITS-1:0]   action,
   input  logic [ple_pkg::POS_BITS-1:0]      position,
   input  logic [ple_pkg::VALUE_BITS-1:0]    value,
   output ple_pkg::cmd_type                  cmd,
   output logic [ple_pkg::STATUS_BITS-1:0]   status,
   output logic [ple_pkg::CNT_BITS-1:0]      count_next
);

   logic [ple_pkg::CNT_BITS-1:0] count_ff;
   logic [ple_pkg::CNT_BITS-1:0] count_in;
   logic [ple_pkg::CMP_BITS-1:0] pos_w;
   logic [ple_pkg::CMP_BITS-1:0] cnt_w;
   logic                         full;
   logic                         empty;
   ple_pkg::op_type              op;
   logic [ple_pkg::CNT_BITS-1:0] idx;

   assign pos_w = ple_pkg::CMP_BITS'(position);
   assign cnt_w = ple_pkg::CMP_BITS'(count_ff);
   assign full  = (count_ff == ple_pkg::CNT_BITS'(ple_pkg::CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      op     = ple_pkg::OP_HOLD;
      idx    = '0;
      status = ple_pkg::ST_OK;
      unique case (action)
         ple_pkg::ACT_ADD_FRONT: begin
            if (full) status = ple_pkg::ST_FULL;
            else      op     = ple_pkg::OP_INSERT;
         end
         ple_pkg::ACT_ADD_REAR: begin
            idx = count_ff;
            if (full) status = ple_pkg::ST_FULL;
            else      op     = ple_pkg::OP_INSERT;
         end
         ple_pkg::ACT_DEL_FRONT: begin
            if (empty) status = ple_pkg::ST_UNDERFLOW;
            else       op     = ple_pkg::OP_REMOVE;
         end
         ple_pkg::ACT_DEL_REAR: begin
            idx = count_ff - 1'b1;
            if (empty) status = ple_pkg::ST_UNDERFLOW;
            else       op     = ple_pkg::OP_REMOVE;
         end
         ple_pkg::ACT_INSERT_AT: begin
            idx = ple_pkg::CNT_BITS'(pos_w - 1'b1);
            if (pos_w == '0 || pos_w > cnt_w + 1'b1) status = ple_pkg::ST_RANGE;
            else if (full)                           status = ple_pkg::ST_FULL;
            else                                     op     = ple_pkg::OP_INSERT;
         end
         ple_pkg::ACT_DELETE_AT: begin
            idx = ple_pkg::CNT_BITS'(pos_w - 1'b1);
            if (pos_w == '0 || pos_w > cnt_w) status = ple_pkg::ST_RANGE;
            else                              op     = ple_pkg::OP_REMOVE;
         end
         default: status = ple_pkg::ST_RANGE;
      endcase
   end

   always_comb begin
      unique case (op)
         ple_pkg::OP_INSERT: count_next = count_ff + 1'b1;
         ple_pkg::OP_REMOVE: count_next = count_ff - 1'b1;
         default:            count_next = count_ff;
      endcase
   end

   assign cmd.op   = accept ? op : ple_pkg::OP_HOLD;
   assign cmd.idx  = idx;
   assign cmd.data = ple_pkg::DATA_BITS'(value);

   assign count_in = accept ? count_next : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: sv/positional_list_engine_top.sv
// Top level of the positional list engine: a row of slot cells plus control.
//
//   channel | direction | beat contents
//   req_    | in        | action, position, value
//   rsp_    | out       | removed_value, status, element_count
//
// The whole row of cells shifts in the cycle the request beat is accepted, so a new
// request can be taken each cycle while the response side does not stall.
// The response beat appears in the cycle after its request is accepted, from a single
// output register. A new request is taken while that register is empty or
// is being emptied in the same cycle; a stalled response stalls the request
// side. Reset empties the list and the output register; the slot contents
// are not cleared, since a slot is read only after it has been written.
module positional_list_engine_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ple_pkg::ACTION_BITS-1:0]   req_action,
   input  logic [ple_pkg::POS_BITS-1:0]      req_position,
   input  logic [ple_pkg::VALUE_BITS-1:0]    req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ple_pkg::VALUE_BITS-1:0]    rsp_removed_value,
   output logic [ple_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [ple_pkg::COUNT_BITS-1:0]    rsp_element_count
);

   localparam int N = ple_pkg::CAPACITY;

   logic                               accept;
   ple_pkg::cmd_type                   cmd;
   logic [ple_pkg::STATUS_BITS-1:0]    status;
   logic [ple_pkg::CNT_BITS-1:0]       count_next;

   logic [ple_pkg::DATA_BITS-1:0]      cell_data [N];
   logic [ple_pkg::DATA_BITS-1:0]      cell_hit  [N];
   logic [ple_pkg::DATA_BITS-1:0]      removed;

   logic                               valid_ff;
   logic                               valid_in;
   logic [ple_pkg::VALUE_BITS-1:0]     removed_ff;
   logic [ple_pkg::STATUS_BITS-1:0]    status_ff;
   logic [ple_pkg::COUNT_BITS-1:0]     count_ff;

   // The request side waits only while a response is held back.
   assign req_stall = valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_action),
      .position   (req_position),
      .value      (req_value),
      .cmd        (cmd),
      .status     (status),
      .count_next (count_next)
   );

   // Slot 0 is the front. On insert each cell past the index takes its left
   // neighbor; on remove each cell from the index on takes its right one.
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [ple_pkg::DATA_BITS-1:0] left_data;
      logic [ple_pkg::DATA_BITS-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == N - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      ple_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (ple_pkg::CNT_BITS'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .hit_data   (cell_hit[i])
      );
   end

   // Only the addressed cell drives a nonzero hit, so an OR picks it out.
   always_comb begin
      removed = '0;
      for (int i = 0; i < N; i++) begin
         removed = removed | cell_hit[i];
      end
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         removed_ff <= (cmd.op == ple_pkg::OP_REMOVE) ?
                       ple_pkg::VALUE_BITS'(removed) : '0;
         status_ff  <= status;
         count_ff   <= ple_pkg::COUNT_BITS'(count_next);
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_element_count = count_ff;

endmodule

FILE: test/positional_list_engine_checker.sv
// Checker that keeps a shadow of the positional list and scores every response beat.
`timescale 1ns / 1ps

module positional_list_engine_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [ple_pkg::ACTION_BITS-1:0]   req_action,
   input  logic [ple_pkg::POS_BITS-1:0]      req_position,
   input  logic [ple_pkg::VALUE_BITS-1:0]    req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [ple_pkg::VALUE_BITS-1:0]    rsp_removed_value,
   input  logic [ple_pkg::STATUS_BITS-1:0]   rsp_status,
   input  logic [ple_pkg::COUNT_BITS-1:0]    rsp_element_count,
   output int                                mismatch_count,
   output int                                pending_count,
   output int                                list_len,
   output int                                peak_len,
   output int                                command_count,
   output int                                full_count,
   output int                                underflow_count,
   output int                                range_count
);
   import ple_pkg::*;

   typedef struct packed {
      logic [VALUE_BITS-1:0]  removed;
      logic [STATUS_BITS-1:0] status;
      logic [COUNT_BITS-1:0]  count;
   } list_outcome_type;

   // Shadow copy of the slot row; slot 0 is the front of the list.
   logic [DATA_BITS-1:0] shadow_slots [CAPACITY];
   int                   shadow_held = 0;
   list_outcome_type     awaited_outcomes [$];

   int fails = 0;
   int peak = 0;
   int cmds = 0;
   int fulls = 0;
   int unders = 0;
   int ranges = 0;

   function automatic void place_at(input int idx, input logic [DATA_BITS-1:0] val);
      for (int i = shadow_held; i > idx; i--) begin
         shadow_slots[i] = shadow_slots[i-1];
      end
      shadow_slots[idx] = val;
      shadow_held++;
   endfunction

   function automatic logic [DATA_BITS-1:0] take_from(input int idx);
      logic [DATA_BITS-1:0] taken;
      taken = shadow_slots[idx];
      for (int i = idx; i < shadow_held - 1; i++) begin
         shadow_slots[i] = shadow_slots[i+1];
      end
      shadow_held--;
      return taken;
   endfunction

   // Applies one command to the shadow list and returns the response it must produce.
   function automatic list_outcome_type apply_command(input logic [ACTION_BITS-1:0] act,
                                                      input logic [POS_BITS-1:0]    pos,
                                                      input logic [VALUE_BITS-1:0]  val);
      list_outcome_type res;
      int               where;
      res.removed = '0;
      res.status  = ST_OK;
      where       = int'(pos);
      case (act)
         ACT_ADD_FRONT, ACT_ADD_REAR: begin
            if (shadow_held >= CAPACITY) begin
               res.status = ST_FULL;
            end else if (act == ACT_ADD_FRONT) begin
               place_at(0, val);
            end else begin
               place_at(shadow_held, val);
            end
         end
         ACT_DEL_FRONT: begin
            if (shadow_held == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               res.removed = take_from(0);
            end
         end
         ACT_DEL_REAR: begin
            if (shadow_held == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               res.removed = take_from(shadow_held - 1);
            end
         end
         ACT_INSERT_AT: begin
            // The position test comes before the full test.
            if (where < 1 || where > shadow_held + 1) begin
               res.status = ST_RANGE;
            end else if (shadow_held >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               place_at(where - 1, val);
            end
         end
         ACT_DELETE_AT: begin
            if (where < 1 || where > shadow_held) begin
               res.status = ST_RANGE;
            end else begin
               res.removed = take_from(where - 1);
            end
         end
         default: begin
            res.status = ST_RANGE;
         end
      endcase
      res.count = COUNT_BITS'(shadow_held);
      return res;
   endfunction

   always @(posedge clock) begin
      list_outcome_type want;
      if (reset) begin
         shadow_held = 0;
         awaited_outcomes.delete();
      end else begin
         // The response leaving now belongs to an older command, so score it first.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               $error("unexpected response beat: removed_value %h status %0d element_count %0d",
                      rsp_removed_value, rsp_status, rsp_element_count);
               fails++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_removed_value !== want.removed) begin
                  $error("removed_value mismatch: expected %h, actual %h",
                         want.removed, rsp_removed_value);
                  fails++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
                  fails++;
               end
               if (rsp_element_count !== want.count) begin
                  $error("element_count mismatch: expected %0d, actual %0d",
                         want.count, rsp_element_count);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_command(req_action, req_position, req_value);
            awaited_outcomes.push_back(want);
            cmds++;
            case (want.status)
               ST_FULL:      fulls++;
               ST_UNDERFLOW: unders++;
               ST_RANGE:     ranges++;
               default:      ;
            endcase
            if (shadow_held > peak) peak = shadow_held;
         end
      end
      mismatch_count  <= fails;
      pending_count   <= awaited_outcomes.size();
      list_len        <= shadow_held;
      peak_len        <= peak;
      command_count   <= cmds;
      full_count      <= fulls;
      underflow_count <= unders;
      range_count     <= ranges;
   end

endmodule

FILE: test/tb_positional_list_engine_top.sv
// Testbench top for the positional list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_positional_list_engine_top;
   import ple_pkg::*;

   // The two action codes the block does not define; both must be rejected as out of range.
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI = 3'd7;

   // Random part: ten phases of equal length. The last one runs without any idling.
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 160;

   // The longest correct quiet stretch is the longest request gap meeting the longest
   // response stall; this limit leaves a wide margin over that.
   localparam int IDLE_LIMIT  = 400;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   logic [ACTION_BITS-1:0]   req_action   = ACT_ADD_FRONT;
   logic [POS_BITS-1:0]      req_position = '0;
   logic [VALUE_BITS-1:0]    req_value    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   logic [VALUE_BITS-1:0]    rsp_removed_value;
   logic [STATUS_BITS-1:0]   rsp_status;
   logic [COUNT_BITS-1:0]    rsp_element_count;

   // When low, neither side inserts gaps or stalls.
   logic                     idling_on    = 1'b0;

   int mismatch_count;
   int pending_count;
   int list_len;
   int peak_len;
   int command_count;
   int full_count;
   int underflow_count;
   int range_count;

   int stall_left   = 0;
   int quiet_cycles = 0;

   always #6 clock = ~clock;

   positional_list_engine_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

   positional_list_engine_checker list_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .list_len          (list_len),
      .peak_len          (peak_len),
      .command_count     (command_count),
      .full_count        (full_count),
      .underflow_count   (underflow_count),
      .range_count       (range_count)
   );

   // Response-side back pressure comes in bursts of random length; between bursts a new
   // one starts with a chance of one in ten while idling is enabled.
   always @(posedge clock) begin
      if (reset || !idling_on) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Watchdog: counts cycles in which no beat moves on either channel. A hang in the
   // block, or a response that never comes, ends the run here.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("positional_list_engine_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one command beat and returns in the time step of the edge that accepts it.
   // The task is entered in the step where the previous beat was taken, so valid stays
   // high straight into the next beat unless a gap is inserted first.
   task automatic issue_command(input logic [ACTION_BITS-1:0] act,
                                input logic [POS_BITS-1:0]    pos,
                                input logic [VALUE_BITS-1:0]  val);
      int gap;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      // A stalled beat keeps its payload until the edge that takes it.
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [VALUE_BITS-1:0] random_value();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return VALUE_BITS'($urandom());
   endfunction

   // One random command. grow_pct is the chance, in percent, that the command adds an
   // element, which steers the list toward full or toward empty over a phase. Positions
   // are mostly legal for the current length; the rest cover the whole field. The
   // length seen here may lag by one beat, which only blurs the aim at the edges.
   task automatic issue_random_command(input int grow_pct);
      int                       len;
      int                       pick;
      logic [ACTION_BITS-1:0]   act;
      logic [POS_BITS-1:0]      pos;
      len  = list_len;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         act = (pick == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
      end else if ($urandom_range(0, 99) < grow_pct) begin
         pick = $urandom_range(0, 3);
         act  = (pick == 0) ? ACT_ADD_FRONT : (pick == 1) ? ACT_ADD_REAR : ACT_INSERT_AT;
      end else begin
         pick = $urandom_range(0, 3);
         act  = (pick == 0) ? ACT_DEL_FRONT : (pick == 1) ? ACT_DEL_REAR : ACT_DELETE_AT;
      end
      if ($urandom_range(0, 6) == 0) begin
         pos = POS_BITS'($urandom_range(0, 255));
      end else if (act == ACT_INSERT_AT) begin
         pos = POS_BITS'($urandom_range(1, len + 1));
      end else begin
         pos = POS_BITS'($urandom_range(1, (len > 0) ? len : 1));
      end
      issue_command(act, pos, random_value());
   endtask

   initial begin
      int grow;
      int pick;
      repeat (11) @(posedge clock);
      reset     <= 1'b0;
      idling_on <= 1'b1;
      @(posedge clock);

      // Directed opening on an empty list: every rejection an empty list can give,
      // including a positional delete, which reports out of range rather than underflow.
      issue_command(ACT_DEL_FRONT, 8'd0, '0);
      issue_command(ACT_DEL_REAR,  8'd0, '0);
      issue_command(ACT_DELETE_AT, 8'd1, '0);
      issue_command(ACT_INSERT_AT, 8'd0, 32'h0BAD_0001);
      issue_command(ACT_INSERT_AT, 8'd2, 32'h0BAD_0002);
      // Insert at position one on an empty list is the same as an append.
      issue_command(ACT_INSERT_AT, 8'd1, 32'h1234_5678);
      issue_command(ACT_ADD_FRONT, 8'hFF, 32'hFFFF_FFFF);
      issue_command(ACT_ADD_REAR,  8'h00, 32'h0000_0000);
      // Position count+1 appends at the rear; position two lands in the middle.
      issue_command(ACT_INSERT_AT, 8'd4, 32'h8000_0001);
      issue_command(ACT_INSERT_AT, 8'd2, 32'hA5A5_5A5A);
      issue_command(ACT_DELETE_AT, 8'd3, '0);
      issue_command(ACT_DELETE_AT, 8'd255, '1);
      issue_command(ACT_DELETE_AT, 8'd0, '0);
      issue_command(ACT_SPARE_LO,  8'hFF, '1);
      issue_command(ACT_SPARE_HI,  8'h01, 32'h5A5A_A5A5);
      issue_command(ACT_DELETE_AT, 8'd4, '0);
      issue_command(ACT_DEL_FRONT, 8'd0, '0);
      issue_command(ACT_DEL_REAR,  8'd0, '0);
      issue_command(ACT_DELETE_AT, 8'd1, '0);

      // Fill the list to capacity with random content and a mix of add styles.
      for (int k = 0; k < CAPACITY; k++) begin
         pick = $urandom_range(0, 2);
         if (pick == 0) issue_command(ACT_ADD_FRONT, 8'd0, random_value());
         else if (pick == 1) issue_command(ACT_ADD_REAR, 8'd0, random_value());
         else issue_command(ACT_INSERT_AT, POS_BITS'($urandom_range(1, k + 1)), random_value());
      end

      // Full list: every add is refused with the full flag, except an insert whose
      // position is illegal, which is refused as out of range because that test comes first.
      issue_command(ACT_ADD_FRONT, 8'd0, random_value());
      issue_command(ACT_ADD_REAR,  8'd0, random_value());
      issue_command(ACT_INSERT_AT, 8'd10, random_value());
      issue_command(ACT_INSERT_AT, POS_BITS'(CAPACITY + 1), random_value());
      issue_command(ACT_INSERT_AT, POS_BITS'(CAPACITY + 2), random_value());
      issue_command(ACT_DELETE_AT, POS_BITS'(CAPACITY + 1), '0);
      issue_command(ACT_DELETE_AT, POS_BITS'(CAPACITY), '0);

      // Drain back to empty, taking elements from the ends and from random positions.
      for (int k = CAPACITY - 1; k > 0; k--) begin
         pick = $urandom_range(0, 2);
         if (pick == 0) issue_command(ACT_DEL_FRONT, 8'd0, '0);
         else if (pick == 1) issue_command(ACT_DEL_REAR, 8'd0, '0);
         else issue_command(ACT_DELETE_AT, POS_BITS'($urandom_range(1, k)), '0);
      end

      // Random phases alternate between growing, shrinking and balanced mixes so the
      // list swings between empty and full several times. Phase four and the final
      // phase run with no gaps or stalls at all.
      for (int phase = 0; phase < PHASES; phase++) begin
         idling_on <= (phase != 4 && phase != PHASES - 1);
         grow = (phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 20 : 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            issue_random_command(grow);
         end
      end

      // Stop sending, let the outstanding responses drain, then give the output
      // register a few more cycles so a stray extra beat would still be caught.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Run covered %0d commands; the list reached %0d of %0d slots.",
               command_count, peak_len, CAPACITY);
      $display("Refused commands: %0d on a full list, %0d on an empty list, %0d out of range.",
               full_count, underflow_count, range_count);
      if (mismatch_count == 0) begin
         $display("positional_list_engine_top regression: pass");
      end else begin
         $display("positional_list_engine_top regression: fail");
      end
      $finish;
   end

endmodule
